// ===== hdl/sorted_priority_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent assertion wrappers. They compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge out of reset.
`define SPQ_ASSERT_HOLDS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sorted priority queue: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define SPQ_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue: implication violated");

// The consequent holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue: sequence violated");

`else

`define SPQ_ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define SPQ_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Field widths, entry and result types, and operation and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DATA_W  = 31;
    localparam int PRIO_W  = 16;
    localparam int COUNT_W = 5;

    // Operation codes carried by the kind field.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        t_entry             removed;
        t_entry             head;
        logic               is_empty;
        logic [COUNT_W-1:0] entry_count;
        t_status            status;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_SCAN,
        S_PUSH_HEAD,
        S_POP_SCAN,
        S_DONE
    } t_state;

endpackage

// ===== hdl/spq_in_if.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue command channel
// Valid/ready channel that carries one push or pop word.
// ----------------------------------------------------------------------------
interface spq_in_if;
    import spq_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [DATA_W-1:0] item_data;
    logic [PRIO_W-1:0] item_priority;

    modport source (output valid, output kind, output item_data, output item_priority,
                    input ready);
    modport sink   (input valid, input kind, input item_data, input item_priority,
                    output ready);
endinterface

// ===== hdl/spq_out_if.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue result channel
// Valid/ready channel that carries one result word per command.
// ----------------------------------------------------------------------------
interface spq_out_if;
    import spq_pkg::*;

    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  removed_data;
    logic [PRIO_W-1:0]  removed_priority;
    logic [DATA_W-1:0]  head_data;
    logic [PRIO_W-1:0]  head_priority;
    logic               is_empty;
    logic [COUNT_W-1:0] entry_count;
    logic [1:0]         status;

    modport source (output valid, output removed_data, output removed_priority,
                    output head_data, output head_priority, output is_empty,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input removed_data, input removed_priority,
                    input head_data, input head_priority, input is_empty,
                    input entry_count, input status, output ready);
endinterface

// ===== hdl/spq_mem.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue entry memory
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  spq_pkg::t_entry i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output spq_pkg::t_entry o_rd_data
);
    import spq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== hdl/spq_out_reg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue output register
// Holds one finished result word until the result channel takes it.
// ----------------------------------------------------------------------------
module spq_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  spq_pkg::t_result i_result,
    output logic             o_free,
    spq_out_if.source        o_out
);
    import spq_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // The register can take a word when empty or when its word leaves now.
    assign o_free = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_free) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_free) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.removed_data     = r_result.removed.data;
    assign o_out.removed_priority = r_result.removed.prio;
    assign o_out.head_data        = r_result.head.data;
    assign o_out.head_priority    = r_result.head.prio;
    assign o_out.is_empty         = r_result.is_empty;
    assign o_out.entry_count      = r_result.entry_count;
    assign o_out.status           = r_result.status;
endmodule

// ===== hdl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue kept sorted in an entry RAM; lowest priority value leaves first.
//
//   Channel  Dir  Payload                                      Handshake
//   i_in     in   kind, item_data, item_priority               valid/ready
//   o_out    out  removed_*, head_*, is_empty, entry_count,    valid/ready
//                 status
//
// One command is worked at a time. The RAM has one read and one write port,
// so the sequencer moves one entry per cycle. A push on a full or empty queue
// needs no scan; else the scan shifts each entry that the new one goes in front
// of one slot toward the tail, whether or not the new entry becomes the head.
// A pop on at most one entry needs no scan; else the rest shift toward the head.
// Reset clears only the control state; the RAM needs no clearing.
// A waiting result stalls the next finished command, not its acceptance.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

`include "sorted_priority_queue_assert.svh"

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    t_state           r_state;
    t_state           n_state;
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    n_idx;
    t_entry           r_new;
    t_entry           n_new;
    t_entry           r_head;
    t_entry           n_head;
    t_entry           r_rem;
    t_entry           n_rem;
    t_status          r_status;
    t_status          n_status;

    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    t_entry           mem_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    t_entry           mem_rd_data;

    logic             res_valid;
    t_result          res;
    logic             out_free;
    logic             shift_up;

    // Entry storage.
    spq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // During a push scan an entry moves up if the new one goes in front of it.
    // Later slots move on equal priority; the head only on strictly greater.
    always_comb begin
        if (r_idx != '0) begin
            shift_up = (mem_rd_data.prio >= r_new.prio);
        end else begin
            shift_up = (mem_rd_data.prio > r_new.prio);
        end
    end

    // Sequencer: next state, RAM accesses and queue bookkeeping.
    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_new       = r_new;
        n_head      = r_head;
        n_rem       = r_rem;
        n_status    = r_status;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = r_new;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        res_valid   = 1'b0;
        i_in.ready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_new.data = i_in.item_data;
                    n_new.prio = i_in.item_priority;
                    n_rem      = '0;
                    n_status   = ST_OK;
                    if (i_in.kind == KIND_PUSH) begin
                        if (r_occ == OCC_W'(DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else if (r_occ == '0) begin
                            mem_wr_en   = 1'b1;
                            mem_wr_data = n_new;
                            n_head      = n_new;
                            n_occ       = OCC_W'(1);
                            n_state     = S_DONE;
                        end else begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = AW'(r_occ - 1'b1);
                            n_idx       = AW'(r_occ - 1'b1);
                            n_state     = S_PUSH_SCAN;
                        end
                    end else begin
                        if (r_occ == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else if (r_occ == OCC_W'(1)) begin
                            n_rem   = r_head;
                            n_occ   = '0;
                            n_state = S_DONE;
                        end else begin
                            n_rem       = r_head;
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = AW'(1);
                            n_idx       = AW'(1);
                            n_state     = S_POP_SCAN;
                        end
                    end
                end
            end

            // Walk from the tail toward the head, moving entries up one slot.
            S_PUSH_SCAN: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_idx + 1'b1;
                if (shift_up) begin
                    mem_wr_data = mem_rd_data;
                    if (r_idx == '0) begin
                        n_state = S_PUSH_HEAD;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = r_idx - 1'b1;
                        n_idx       = r_idx - 1'b1;
                    end
                end else begin
                    mem_wr_data = r_new;
                    n_occ       = r_occ + 1'b1;
                    n_state     = S_DONE;
                end
            end

            // The new entry takes the head slot.
            S_PUSH_HEAD: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = '0;
                mem_wr_data = r_new;
                n_head      = r_new;
                n_occ       = r_occ + 1'b1;
                n_state     = S_DONE;
            end

            // Walk from slot one to the tail, moving entries down one slot.
            S_POP_SCAN: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_idx - 1'b1;
                mem_wr_data = mem_rd_data;
                if (r_idx == AW'(1)) begin
                    n_head = mem_rd_data;
                end
                if (OCC_W'(r_idx) == r_occ - 1'b1) begin
                    n_occ   = r_occ - 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_idx + 1'b1;
                    n_idx       = r_idx + 1'b1;
                end
            end

            // Hand the result word to the output register.
            S_DONE: begin
                res_valid = 1'b1;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
        end
    end

    // Working registers and head copy; valid only while r_occ says so.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_new    <= n_new;
        r_head   <= n_head;
        r_rem    <= n_rem;
        r_status <= n_status;
    end

    // Result word as seen after the command.
    always_comb begin
        res.removed     = r_rem;
        res.head        = (r_occ != '0) ? r_head : '0;
        res.is_empty    = (r_occ == '0);
        res.entry_count = COUNT_W'(r_occ);
        res.status      = r_status;
    end

    spq_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .i_result (res),
        .o_free   (out_free),
        .o_out    (o_out)
    );

    // Checks on the sequencer.
    `SPQ_ASSERT_HOLDS(a_occ_bound, i_clk, i_rst_n, r_occ <= OCC_W'(DEPTH))
    `SPQ_ASSERT_IMPLIES(a_no_same_addr, i_clk, i_rst_n, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr)
    `SPQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state != S_IDLE)
    `SPQ_ASSERT_IMPLIES(a_full_status, i_clk, i_rst_n, res_valid && (r_status == ST_FULL), r_occ == OCC_W'(DEPTH))
endmodule
